### sv/tiled_texture_mask_modulator_unit_defines.svh
// assertion macros for the texture mask modulator
`ifndef TILED_TEXTURE_MASK_MODULATOR_UNIT_DEFINES_SVH
`define TILED_TEXTURE_MASK_MODULATOR_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define TTM_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define TTM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TTM_ASSERT(lbl, clk, rst_n, prop, msg)
`define TTM_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

### sv/ttm_pkg.sv
`timescale 1ns / 1ps
// shared types, constants and register codes for the texture mask modulator
package ttm_pkg;

  localparam int TTM_TEX_MAX_W  = 256;
  localparam int TTM_TEX_MAX_H  = 256;
  localparam int TTM_RAW_ADDR_W = 18;
  localparam int TTM_CFG_IDX_W  = 3;
  localparam int TTM_CFG_DATA_W = 24;
  localparam int TTM_Q_DEPTH    = 4;
  localparam int TTM_Q_PTR_W    = $clog2(TTM_Q_DEPTH);
  localparam int TTM_Q_CNT_W    = $clog2(TTM_Q_DEPTH + 1);

  localparam logic [TTM_CFG_IDX_W-1:0] TTM_REG_BLEND     = 3'd0;
  localparam logic [TTM_CFG_IDX_W-1:0] TTM_REG_FLOOR     = 3'd1;
  localparam logic [TTM_CFG_IDX_W-1:0] TTM_REG_GAIN      = 3'd2;
  localparam logic [TTM_CFG_IDX_W-1:0] TTM_REG_STEP      = 3'd3;
  localparam logic [TTM_CFG_IDX_W-1:0] TTM_REG_WIDTH     = 3'd4;
  localparam logic [TTM_CFG_IDX_W-1:0] TTM_REG_HEIGHT    = 3'd5;
  localparam logic [TTM_CFG_IDX_W-1:0] TTM_REG_START_COL = 3'd6;
  localparam logic [TTM_CFG_IDX_W-1:0] TTM_REG_START_ROW = 3'd7;

  typedef struct packed {
    logic [16:0] blend;
    logic [15:0] tone_floor;
    logic [15:0] gain;
    logic [23:0] step;
    logic [8:0]  tex_width;
    logic [8:0]  tex_height;
    logic [23:0] start_col;
    logic [23:0] start_row;
  } ttm_cfg_t;

  localparam ttm_cfg_t TTM_CFG_RST = '{
    blend:      17'd0,
    tone_floor: 16'd0,
    gain:       16'd0,
    step:       24'd65536,
    tex_width:  9'd256,
    tex_height: 9'd256,
    start_col:  24'd0,
    start_row:  24'd0
  };

  typedef struct packed {
    logic        is_pix;
    logic [15:0] index;
    logic [7:0]  value;
    logic [15:0] mask;
    logic [23:0] col;
    logic [23:0] row;
  } ttm_entry_t;

  typedef struct packed {
    logic                      vld;
    logic                      wr;
    logic [TTM_RAW_ADDR_W-1:0] addr;
    logic [7:0]                data;
  } ttm_tex_req_t;

  typedef struct packed {
    logic       vld;
    logic [7:0] data;
  } ttm_tex_rsp_t;

  typedef enum logic [2:0] {
    TTM_B_IDLE,
    TTM_B_ISSUE,
    TTM_B_WAIT,
    TTM_B_LERP_X,
    TTM_B_LERP_Y,
    TTM_B_TONE_A,
    TTM_B_TONE_B,
    TTM_B_OUT
  } ttm_bstate_t;

endpackage

### sv/tiled_texture_mask_modulator_unit.sv
`timescale 1ns / 1ps
// top level of the tiled texture mask modulator
// Words with req_type 0 write one texel into an internal texel memory of
// TEX_MAX_W * TEX_MAX_H bytes (addresses wrap at that size); words with
// req_type 1 are mask pixels and each gives one mask_out word. Texels are
// undefined until written, and there is no clearing pass after reset. The
// front end takes a word every cycle while its four-entry queue has room and
// keeps the column and row phases. Texel writes leave the queue at one per
// cycle while the back end is idle. A nonzero pixel issues four texel reads
// one per cycle into the single-port texel memory through its address
// multiply, wrap and read stages, then interpolation, blend, tone and output
// steps; a zero pixel goes straight to output. The output register lets the
// back end finish the next pixel while a result waits. Configuration must be
// written only while the block is idle; the block does not enforce it.
module tiled_texture_mask_modulator_unit #(
  parameter int TEX_MAX_W = ttm_pkg::TTM_TEX_MAX_W,
  parameter int TEX_MAX_H = ttm_pkg::TTM_TEX_MAX_H
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [ttm_pkg::TTM_CFG_IDX_W-1:0]  cfg_index,
  input  logic [ttm_pkg::TTM_CFG_DATA_W-1:0] cfg_wdata,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               in_req_type,
  input  logic [15:0]                        in_texel_index,
  input  logic [7:0]                         in_texel_value,
  input  logic [15:0]                        in_mask_in,
  input  logic                               in_first_pixel,
  input  logic                               in_row_end,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [15:0]                        out_mask_out
);

  ttm_pkg::ttm_cfg_t     cfg_r;
  ttm_pkg::ttm_entry_t   q_wdata, q_rdata;
  ttm_pkg::ttm_tex_req_t tex_req;
  ttm_pkg::ttm_tex_rsp_t tex_rsp;
  logic                  q_push, q_full, q_pop, q_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= ttm_pkg::TTM_CFG_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ttm_pkg::TTM_REG_BLEND:     cfg_r.blend      <= cfg_wdata[16:0];
        ttm_pkg::TTM_REG_FLOOR:     cfg_r.tone_floor <= cfg_wdata[15:0];
        ttm_pkg::TTM_REG_GAIN:      cfg_r.gain       <= cfg_wdata[15:0];
        ttm_pkg::TTM_REG_STEP:      cfg_r.step       <= cfg_wdata[23:0];
        ttm_pkg::TTM_REG_WIDTH:     cfg_r.tex_width  <= cfg_wdata[8:0];
        ttm_pkg::TTM_REG_HEIGHT:    cfg_r.tex_height <= cfg_wdata[8:0];
        ttm_pkg::TTM_REG_START_COL: cfg_r.start_col  <= cfg_wdata[23:0];
        ttm_pkg::TTM_REG_START_ROW: cfg_r.start_row  <= cfg_wdata[23:0];
        default: ;
      endcase
    end
  end

  ttm_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg_r),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_req_type    (in_req_type),
    .in_texel_index (in_texel_index),
    .in_texel_value (in_texel_value),
    .in_mask_in     (in_mask_in),
    .in_first_pixel (in_first_pixel),
    .in_row_end     (in_row_end),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_wdata        (q_wdata)
  );

  ttm_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .valid (q_valid),
    .rdata (q_rdata)
  );

  ttm_texmem #(
    .TEX_MAX_W (TEX_MAX_W),
    .TEX_MAX_H (TEX_MAX_H)
  ) u_texmem (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (tex_req),
    .rsp   (tex_rsp)
  );

  ttm_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg_r),
    .q_valid      (q_valid),
    .q_rdata      (q_rdata),
    .q_pop        (q_pop),
    .req          (tex_req),
    .rsp          (tex_rsp),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_mask_out (out_mask_out)
  );

endmodule

### sv/ttm_front.sv
`timescale 1ns / 1ps
// front end: accepts words, classifies them and tracks the texture phases
`include "tiled_texture_mask_modulator_unit_defines.svh"
module ttm_front (
  input  logic                clk,
  input  logic                rst_n,
  input  ttm_pkg::ttm_cfg_t   cfg,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_req_type,
  input  logic [15:0]         in_texel_index,
  input  logic [7:0]          in_texel_value,
  input  logic [15:0]         in_mask_in,
  input  logic                in_first_pixel,
  input  logic                in_row_end,
  input  logic                q_full,
  output logic                q_push,
  output ttm_pkg::ttm_entry_t q_wdata
);

  logic [23:0] col_r, col_nxt;
  logic [23:0] row_r, row_nxt;
  logic [23:0] cur_col, cur_row;
  logic        acc;

  function automatic logic [23:0] advance(input logic [23:0] phase, input logic [23:0] step,
                                          input logic [8:0] size);
    logic [24:0] sum;
    logic [24:0] lim;
    sum = {1'b0, phase} + {1'b0, step};
    lim = {size, 16'd0};
    if (sum >= lim) sum = sum - lim;
    return sum[23:0];
  endfunction

  assign in_ready = !q_full;
  assign acc      = in_valid && in_ready;
  assign q_push   = acc;

  always_comb begin
    cur_col = in_first_pixel ? cfg.start_col : col_r;
    cur_row = in_first_pixel ? cfg.start_row : row_r;

    q_wdata.is_pix = in_req_type;
    q_wdata.index  = in_texel_index;
    q_wdata.value  = in_texel_value;
    q_wdata.mask   = in_mask_in;
    q_wdata.col    = cur_col;
    q_wdata.row    = cur_row;

    col_nxt = col_r;
    row_nxt = row_r;
    if (acc && in_req_type) begin
      col_nxt = advance(cur_col, cfg.step, cfg.tex_width);
      row_nxt = cur_row;
      if (in_row_end) begin
        col_nxt = cfg.start_col;
        row_nxt = advance(cur_row, cfg.step, cfg.tex_height);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  `TTM_ASSERT(a_write_keeps_phase, clk, rst_n, (acc && !in_req_type) |=> ($stable(col_r) && $stable(row_r)), "texel write moved phases")

endmodule

### sv/ttm_fifo.sv
`timescale 1ns / 1ps
// short queue between the front end and the back end
`include "tiled_texture_mask_modulator_unit_defines.svh"
module ttm_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  ttm_pkg::ttm_entry_t wdata,
  output logic                full,
  input  logic                pop,
  output logic                valid,
  output ttm_pkg::ttm_entry_t rdata
);

  localparam int DEPTH = ttm_pkg::TTM_Q_DEPTH;
  localparam int PTR_W = ttm_pkg::TTM_Q_PTR_W;
  localparam int CNT_W = ttm_pkg::TTM_Q_CNT_W;

  ttm_pkg::ttm_entry_t mem_r [DEPTH];
  logic [PTR_W-1:0]    wr_ptr_r;
  logic [PTR_W-1:0]    rd_ptr_r;
  logic [CNT_W-1:0]    cnt_r;

  assign full  = (cnt_r == CNT_W'(DEPTH));
  assign valid = (cnt_r != '0);
  assign rdata = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop) rd_ptr_r <= rd_ptr_r + 1'b1;
      cnt_r <= cnt_r + CNT_W'(push) - CNT_W'(pop);
    end
  end

  `TTM_ASSERT(a_q_pop_nonempty, clk, rst_n, pop |-> valid, "pop from empty queue")
  `TTM_ASSERT(a_q_count_up, clk, rst_n, (push && !pop) |=> (cnt_r == $past(cnt_r) + 1'b1), "queue count slip")

endmodule

### sv/ttm_texmem.sv
`timescale 1ns / 1ps
// texel store with the address wrap pipeline in front of it
`include "tiled_texture_mask_modulator_unit_defines.svh"
module ttm_texmem #(
  parameter int TEX_MAX_W = ttm_pkg::TTM_TEX_MAX_W,
  parameter int TEX_MAX_H = ttm_pkg::TTM_TEX_MAX_H
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  ttm_pkg::ttm_tex_req_t req,
  output ttm_pkg::ttm_tex_rsp_t rsp
);

  localparam int DEPTH   = TEX_MAX_W * TEX_MAX_H;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int RAW_W   = ttm_pkg::TTM_RAW_ADDR_W;
  localparam int SHIFT   = RAW_W + ADDR_W;
  localparam int RECIP_W = RAW_W + 2;
  localparam int PROD_W  = RAW_W + RECIP_W;
  localparam longint unsigned RECIP = ((64'd1 << SHIFT) + DEPTH - 1) / DEPTH;

  logic [PROD_W-1:0] prod;
  logic [31:0]       rem;

  logic              v2_r, wr2_r;
  logic [RAW_W-1:0]  raw2_r, quo_r;
  logic [7:0]        data2_r;

  logic              v3_r, wr3_r;
  logic [ADDR_W-1:0] addr3_r;
  logic [7:0]        data3_r;

  logic              rvld_r;
  logic [7:0]        rdata_r;
  logic [7:0]        mem [DEPTH];

  // floor(a / DEPTH) by reciprocal, exact for every raw address
  assign prod = PROD_W'(req.addr) * PROD_W'(RECIP);
  assign rem  = 32'(raw2_r) - 32'(quo_r) * 32'(DEPTH);

  always_ff @(posedge clk) begin
    raw2_r  <= req.addr;
    quo_r   <= RAW_W'(prod >> SHIFT);
    data2_r <= req.data;
    wr2_r   <= req.wr;
    addr3_r <= rem[ADDR_W-1:0];
    data3_r <= data2_r;
    wr3_r   <= wr2_r;
  end

  always_ff @(posedge clk) begin
    if (v3_r && wr3_r) mem[addr3_r] <= data3_r;
    rdata_r <= mem[addr3_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r   <= 1'b0;
      v3_r   <= 1'b0;
      rvld_r <= 1'b0;
    end else begin
      v2_r   <= req.vld;
      v3_r   <= v2_r;
      rvld_r <= v3_r && !wr3_r;
    end
  end

  assign rsp.vld  = rvld_r;
  assign rsp.data = rdata_r;

  `TTM_ASSERT(a_rd_from_read, clk, rst_n, rvld_r |-> $past(v3_r && !wr3_r), "read data without a read")

endmodule

### sv/ttm_back.sv
`timescale 1ns / 1ps
// back end: texel fetch sequencing, bilinear sample, blend, tone and output
`include "tiled_texture_mask_modulator_unit_defines.svh"
module ttm_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  ttm_pkg::ttm_cfg_t     cfg,
  input  logic                  q_valid,
  input  ttm_pkg::ttm_entry_t   q_rdata,
  output logic                  q_pop,
  output ttm_pkg::ttm_tex_req_t req,
  input  ttm_pkg::ttm_tex_rsp_t rsp,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [15:0]           out_mask_out
);

  localparam int RAW_W = ttm_pkg::TTM_RAW_ADDR_W;
  localparam logic [2:0] TAPS = 3'd4;
  localparam logic [1:0] LAST_TAP = 2'd3;

  ttm_pkg::ttm_bstate_t  state_r, state_nxt;
  ttm_pkg::ttm_entry_t   ent_r;
  ttm_pkg::ttm_tex_req_t req_r, req_nxt;
  logic [1:0]            k_r;
  logic [2:0]            cnt_r;
  logic [7:0]            tex_r [4];
  logic [7:0]            top_r, bot_r, smp_r;
  logic [15:0]           m_r, g_r;
  logic                  out_valid_r;
  logic [15:0]           mask_out_r;

  logic                  ent_ld, wr_issue, rd_issue, out_ld;
  logic [8:0]            xs, ys, xw, yw;
  logic [RAW_W-1:0]      row_base, raw;
  logic [7:0]            lerp_y, smp_nxt;
  logic [24:0]           prod_a;
  logic [16:0]           m_nxt;
  logic [15:0]           tlev, mm, dlt;
  logic [31:0]           prod_b;
  logic [32:0]           prod_o;

  function automatic logic [7:0] lerp(input logic [7:0] a, input logic [7:0] b,
                                      input logic [15:0] f);
    logic signed [8:0]  diff;
    logic signed [26:0] v;
    logic signed [10:0] q;
    logic signed [11:0] s;
    diff = $signed({1'b0, b}) - $signed({1'b0, a});
    v    = diff * $signed({1'b0, f}) + 27'sd65535;
    q    = v[26:16];
    s    = $signed({4'b0, a}) + q;
    if (s < 0) return 8'd0;
    else if (s > 12'sd255) return 8'd255;
    else return s[7:0];
  endfunction

  // state machine
  always_comb begin
    state_nxt = state_r;
    q_pop     = 1'b0;
    ent_ld    = 1'b0;
    wr_issue  = 1'b0;
    rd_issue  = 1'b0;
    out_ld    = 1'b0;
    unique case (state_r)
      ttm_pkg::TTM_B_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          if (!q_rdata.is_pix) begin
            wr_issue = 1'b1;
          end else begin
            ent_ld    = 1'b1;
            state_nxt = (q_rdata.mask == '0) ? ttm_pkg::TTM_B_OUT : ttm_pkg::TTM_B_ISSUE;
          end
        end
      end
      ttm_pkg::TTM_B_ISSUE: begin
        rd_issue = 1'b1;
        if (k_r == LAST_TAP) state_nxt = ttm_pkg::TTM_B_WAIT;
      end
      ttm_pkg::TTM_B_WAIT: begin
        if (cnt_r == TAPS) state_nxt = ttm_pkg::TTM_B_LERP_X;
      end
      ttm_pkg::TTM_B_LERP_X: state_nxt = ttm_pkg::TTM_B_LERP_Y;
      ttm_pkg::TTM_B_LERP_Y: state_nxt = ttm_pkg::TTM_B_TONE_A;
      ttm_pkg::TTM_B_TONE_A: state_nxt = ttm_pkg::TTM_B_TONE_B;
      ttm_pkg::TTM_B_TONE_B: state_nxt = ttm_pkg::TTM_B_OUT;
      ttm_pkg::TTM_B_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_ld    = 1'b1;
          state_nxt = ttm_pkg::TTM_B_IDLE;
        end
      end
      default: state_nxt = ttm_pkg::TTM_B_IDLE;
    endcase
  end

  // texel address for the current tap
  always_comb begin
    xs       = {1'b0, ent_r.col[23:16]} + {8'd0, k_r[0]};
    ys       = {1'b0, ent_r.row[23:16]} + {8'd0, k_r[1]};
    xw       = (xs >= cfg.tex_width) ? xs - cfg.tex_width : xs;
    yw       = (ys >= cfg.tex_height) ? ys - cfg.tex_height : ys;
    row_base = RAW_W'(yw) * RAW_W'(cfg.tex_width);
    raw      = row_base + RAW_W'(xw);

    req_nxt = '0;
    if (wr_issue) begin
      req_nxt.vld  = 1'b1;
      req_nxt.wr   = 1'b1;
      req_nxt.addr = RAW_W'(q_rdata.index);
      req_nxt.data = q_rdata.value;
    end else if (rd_issue) begin
      req_nxt.vld  = 1'b1;
      req_nxt.addr = raw;
    end
  end

  // sample and tone math
  always_comb begin
    lerp_y  = lerp(top_r, bot_r, ent_r.row[15:0]);
    smp_nxt = cfg.blend[16] ? 8'd255 - lerp_y : lerp_y;
    prod_a  = 25'(smp_r) * 25'(cfg.blend[15:0]) + 25'(cfg.blend[15:0]);
    m_nxt   = 17'(prod_a >> 8) + 17'(~cfg.blend[15:0]);
    tlev    = ~cfg.tone_floor;
    mm      = (m_r < tlev) ? tlev : m_r;
    dlt     = mm - tlev;
    prod_b  = 32'(dlt) * 32'(cfg.gain);
    prod_o  = 33'(ent_r.mask) * 33'(g_r) + 33'd65535;
  end

  always_ff @(posedge clk) begin
    if (ent_ld) ent_r <= q_rdata;
    if (rsp.vld) begin
      tex_r[0] <= tex_r[1];
      tex_r[1] <= tex_r[2];
      tex_r[2] <= tex_r[3];
      tex_r[3] <= rsp.data;
    end
    case (state_r)
      ttm_pkg::TTM_B_LERP_X: begin
        top_r <= lerp(tex_r[0], tex_r[1], ent_r.col[15:0]);
        bot_r <= lerp(tex_r[2], tex_r[3], ent_r.col[15:0]);
      end
      ttm_pkg::TTM_B_LERP_Y: smp_r <= smp_nxt;
      ttm_pkg::TTM_B_TONE_A: m_r <= m_nxt[15:0];
      ttm_pkg::TTM_B_TONE_B: g_r <= prod_b[31:16];
      default: ;
    endcase
    if (out_ld) mask_out_r <= (ent_r.mask == '0) ? 16'd0 : prod_o[31:16];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ttm_pkg::TTM_B_IDLE;
      req_r       <= '0;
      k_r         <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      req_r   <= req_nxt;
      if (rd_issue) k_r <= k_r + 1'b1;
      if (state_r == ttm_pkg::TTM_B_WAIT && cnt_r == TAPS) cnt_r <= '0;
      else if (rsp.vld) cnt_r <= cnt_r + 1'b1;
      if (out_ld) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  assign req          = req_r;
  assign out_valid    = out_valid_r;
  assign out_mask_out = mask_out_r;

  `TTM_ASSERT(a_rsp_in_window, clk, rst_n, rsp.vld |-> (state_r == ttm_pkg::TTM_B_ISSUE || state_r == ttm_pkg::TTM_B_WAIT), "stray texel data")
  `TTM_ASSERT(a_taps_done, clk, rst_n, (state_r == ttm_pkg::TTM_B_LERP_X) |-> (cnt_r == '0 && k_r == '0), "tap count slip")

endmodule

### tb/tiled_texture_mask_modulator_unit_tb.sv
`timescale 1ns / 1ps
// self-checking testbench for the tiled texture mask modulator: texel loads, mask pixels, idling
module tiled_texture_mask_modulator_unit_tb;
  import ttm_pkg::*;

  localparam int TEX_DEPTH    = TTM_TEX_MAX_W * TTM_TEX_MAX_H;
  localparam int DRAIN_CYCLES = 40;
  localparam int STALL_LIMIT  = 5000;
  localparam int HOLD_CYCLES  = 300;
  localparam int PHASES       = 8;
  localparam int PHASE_WORDS  = 190;

  typedef enum logic {
    REQ_TEXEL = 1'b0,
    REQ_PIXEL = 1'b1
  } req_kind_t;

  typedef struct {
    req_kind_t   kind;
    logic [15:0] tidx;
    logic [7:0]  tval;
    logic [15:0] mask;
    logic        first;
    logic        rend;
    logic        has_res;
    logic [15:0] res;
  } mask_word_t;

  logic                      clk            = 1'b0;
  logic                      rst_n          = 1'b0;
  logic                      cfg_we         = 1'b0;
  logic [TTM_CFG_IDX_W-1:0]  cfg_index      = '0;
  logic [TTM_CFG_DATA_W-1:0] cfg_wdata      = '0;
  logic                      in_valid       = 1'b0;
  logic                      in_ready;
  logic                      in_req_type    = 1'b0;
  logic [15:0]               in_texel_index = '0;
  logic [7:0]                in_texel_value = '0;
  logic [15:0]               in_mask_in     = '0;
  logic                      in_first_pixel = 1'b0;
  logic                      in_row_end     = 1'b0;
  logic                      out_valid;
  logic                      out_ready      = 1'b0;
  logic [15:0]               out_mask_out;

  mask_word_t  pending_words[$];
  logic [15:0] expected_out[$];
  mask_word_t  cur_word;

  logic [7:0]  tex_mem [TEX_DEPTH];
  bit          tex_written [TEX_DEPTH];
  logic [23:0] col_ph;
  logic [23:0] row_ph;
  ttm_cfg_t    mod_cfg;

  int  words_queued  = 0;
  int  mismatches    = 0;
  int  src_idle_pct  = 0;
  int  snk_stall_pct = 0;
  bit  hold_req      = 1'b0;
  logic hold_done;
  int  hold_left;

  tiled_texture_mask_modulator_unit u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_req_type    (in_req_type),
    .in_texel_index (in_texel_index),
    .in_texel_value (in_texel_value),
    .in_mask_in     (in_mask_in),
    .in_first_pixel (in_first_pixel),
    .in_row_end     (in_row_end),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_mask_out   (out_mask_out)
  );

  always #10 clk = ~clk;

  function automatic logic [15:0] tap_addr(logic [23:0] cp, logic [23:0] rp, int k);
    int unsigned x, y, w, h;
    w = mod_cfg.tex_width;
    h = mod_cfg.tex_height;
    x = int'(cp[23:16]) + (k & 1);
    y = int'(rp[23:16]) + (k >> 1);
    if (x >= w) x -= w;
    if (y >= h) y -= h;
    return 16'((y * w + x) % TEX_DEPTH);
  endfunction

  function automatic int interp(int a, int b, int unsigned f);
    longint v;
    v = longint'(b - a) * longint'(f) + 65535;
    return a + int'(v >>> 16);
  endfunction

  function automatic int unsigned bilinear_tap(logic [23:0] cp, logic [23:0] rp);
    int top, bot, r;
    top = interp(tex_mem[tap_addr(cp, rp, 0)], tex_mem[tap_addr(cp, rp, 1)], cp[15:0]);
    bot = interp(tex_mem[tap_addr(cp, rp, 2)], tex_mem[tap_addr(cp, rp, 3)], cp[15:0]);
    r = interp(top, bot, rp[15:0]);
    if (r < 0) r = 0;
    if (r > 255) r = 255;
    return r;
  endfunction

  function automatic logic [23:0] step_phase(logic [23:0] ph, logic [8:0] size);
    int unsigned lim, sum;
    lim = int'(size) << 16;
    sum = int'(ph) + int'(mod_cfg.step);
    if (sum >= lim) sum -= lim;
    return sum[23:0];
  endfunction

  // updates the phase accumulators and returns the modulated pixel
  function automatic logic [15:0] modulate_pixel(logic [15:0] pix, logic first, logic rend);
    int unsigned s, f, m, t;
    longint unsigned prod;
    if (first) begin
      col_ph = mod_cfg.start_col;
      row_ph = mod_cfg.start_row;
    end
    m = 0;
    if (pix != 0) begin
      f = mod_cfg.blend[15:0];
      s = bilinear_tap(col_ph, row_ph);
      if (mod_cfg.blend[16]) s = 255 - s;
      m = (s * f + f) >> 8;
      m += 65535 - f;
      t = 65535 - int'(mod_cfg.tone_floor);
      if (m < t) m = t;
      prod = m - t;
      prod = (prod * mod_cfg.gain) >> 16;
      prod = (longint'(pix) * prod + 65535) >> 16;
      m = prod[31:0];
    end
    col_ph = step_phase(col_ph, mod_cfg.tex_width);
    if (rend) begin
      col_ph = mod_cfg.start_col;
      row_ph = step_phase(row_ph, mod_cfg.tex_height);
    end
    return m[15:0];
  endfunction

  function automatic logic [15:0] rand_mask();
    case ($urandom_range(9))
      0, 1: return 16'h0000;
      2: return 16'hFFFF;
      3: return 16'h0001;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic queue_texel(logic [15:0] idx, logic [7:0] val);
    mask_word_t w;
    w.kind    = REQ_TEXEL;
    w.tidx    = idx;
    w.tval    = val;
    w.mask    = 16'($urandom);
    w.first   = 1'($urandom);
    w.rend    = 1'($urandom);
    w.has_res = 1'b0;
    w.res     = '0;
    tex_mem[idx]     = val;
    tex_written[idx] = 1'b1;
    pending_words.push_back(w);
    words_queued++;
  endtask

  // texels a nonzero pixel will read get written first if still unknown
  task automatic queue_pixel(logic [15:0] pix, logic first, logic rend);
    mask_word_t  w;
    logic [23:0] cp, rp;
    logic [15:0] a;
    cp = first ? mod_cfg.start_col : col_ph;
    rp = first ? mod_cfg.start_row : row_ph;
    if (pix != 0) begin
      for (int k = 0; k < 4; k++) begin
        a = tap_addr(cp, rp, k);
        if (!tex_written[a]) queue_texel(a, 8'($urandom));
      end
    end
    w.kind    = REQ_PIXEL;
    w.tidx    = 16'($urandom);
    w.tval    = 8'($urandom);
    w.mask    = pix;
    w.first   = first;
    w.rend    = rend;
    w.has_res = 1'b1;
    w.res     = modulate_pixel(pix, first, rend);
    pending_words.push_back(w);
    words_queued++;
  endtask

  // raster regions with random content, plus stray writes and broken marks
  task automatic queue_region(int n_words);
    int   target, row_len, n_rows, col_pos, row_pos, sel;
    logic last;
    target  = words_queued + n_words;
    row_len = $urandom_range(1, 12);
    n_rows  = $urandom_range(1, 6);
    col_pos = 0;
    row_pos = 0;
    while (words_queued < target) begin
      sel = $urandom_range(19);
      if (sel == 0) begin
        queue_texel(16'($urandom), 8'($urandom));
      end else if (sel == 1) begin
        queue_pixel(rand_mask(), 1'($urandom), 1'($urandom));
      end else begin
        last = (col_pos == row_len - 1);
        queue_pixel(rand_mask(), col_pos == 0 && row_pos == 0, last);
        col_pos++;
        if (last) begin
          col_pos = 0;
          row_pos++;
          if (row_pos == n_rows) begin
            row_pos = 0;
            row_len = $urandom_range(1, 12);
            n_rows  = $urandom_range(1, 6);
          end
        end
      end
    end
  endtask

  task automatic write_reg(logic [TTM_CFG_IDX_W-1:0] idx, logic [TTM_CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      TTM_REG_BLEND:     mod_cfg.blend      = data[16:0];
      TTM_REG_FLOOR:     mod_cfg.tone_floor = data[15:0];
      TTM_REG_GAIN:      mod_cfg.gain       = data[15:0];
      TTM_REG_STEP:      mod_cfg.step       = data[23:0];
      TTM_REG_WIDTH:     mod_cfg.tex_width  = data[8:0];
      TTM_REG_HEIGHT:    mod_cfg.tex_height = data[8:0];
      TTM_REG_START_COL: mod_cfg.start_col  = data[23:0];
      TTM_REG_START_ROW: mod_cfg.start_row  = data[23:0];
      default: ;
    endcase
  endtask

  task automatic apply_cfg(ttm_cfg_t c);
    write_reg(TTM_REG_BLEND,     24'(c.blend));
    write_reg(TTM_REG_FLOOR,     24'(c.tone_floor));
    write_reg(TTM_REG_GAIN,      24'(c.gain));
    write_reg(TTM_REG_STEP,      c.step);
    write_reg(TTM_REG_WIDTH,     24'(c.tex_width));
    write_reg(TTM_REG_HEIGHT,    24'(c.tex_height));
    write_reg(TTM_REG_START_COL, c.start_col);
    write_reg(TTM_REG_START_ROW, c.start_row);
  endtask

  function automatic ttm_cfg_t pick_cfg(int p);
    ttm_cfg_t    c;
    int unsigned wspan, hspan;
    c.blend      = 17'($urandom);
    c.tone_floor = 16'($urandom);
    c.gain       = 16'($urandom);
    c.tex_width  = 9'($urandom_range(1, 24));
    c.tex_height = 9'($urandom_range(1, 24));
    if (p == 5) begin
      c.tex_width  = 9'd256;
      c.tex_height = 9'd256;
    end
    wspan       = int'(c.tex_width) << 16;
    hspan       = int'(c.tex_height) << 16;
    c.step      = 24'($urandom_range(0, ((wspan < hspan) ? wspan : hspan) - 1));
    c.start_col = 24'($urandom_range(0, wspan - 1));
    c.start_row = 24'($urandom_range(0, hspan - 1));
    case (p)
      0: c = TTM_CFG_RST;
      1: c = '{17'h1FFFF, 16'hFFFF, 16'hFFFF, 24'h003000, 9'd1, 9'd1, 24'h0, 24'h0};
      3: c = '{c.blend, 16'h0000, 16'hFFFF, 24'hFFFFFF, 9'd7, 9'd9, 24'hFFFFFF, 24'hFFFFFF};
      5: c.step = 24'($urandom_range(0, 16'h3FFF));
      6: c.step = 24'h0;
      default: ;
    endcase
    return c;
  endfunction

  task automatic wait_idle();
    @(negedge clk);
    while (pending_words.size() != 0 || in_valid || expected_out.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic void note_mismatch(string what, logic [15:0] want, logic [15:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch (%s) at %0t: expected mask_out %h, got %h", what, $time, want, got);
  endfunction

  // input word driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (in_valid && cur_word.has_res) expected_out.push_back(cur_word.res);
      if (pending_words.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
        cur_word = pending_words.pop_front();
        in_valid       <= 1'b1;
        in_req_type    <= cur_word.kind;
        in_texel_index <= cur_word.tidx;
        in_texel_value <= cur_word.tval;
        in_mask_in     <= cur_word.mask;
        in_first_pixel <= cur_word.first;
        in_row_end     <= cur_word.rend;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result monitor and receiver stalls
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      hold_done <= 1'b0;
      hold_left <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_out.size() == 0) begin
          note_mismatch("unexpected word", 'x, out_mask_out);
        end else if (expected_out[0] !== out_mask_out) begin
          note_mismatch("mask_out", expected_out[0], out_mask_out);
          void'(expected_out.pop_front());
        end else begin
          void'(expected_out.pop_front());
        end
      end
      if (hold_req && !hold_done) begin
        hold_done <= 1'b1;
        hold_left <= HOLD_CYCLES;
        out_ready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= snk_stall_pct);
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    mod_cfg = TTM_CFG_RST;
    col_ph  = '0;
    row_ph  = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed: 2x2 texture, inverted samples, half-texel step
    apply_cfg('{17'h1C000, 16'h8000, 16'hFFFF, 24'h008000, 9'd2, 9'd2, 24'h0, 24'h008000});
    queue_texel(16'h0000, 8'h00);
    queue_texel(16'h0001, 8'hFF);
    queue_texel(16'h0002, 8'h80);
    queue_texel(16'h0003, 8'h07);
    queue_texel(16'hFFFF, 8'hFF);
    queue_pixel(16'hFFFF, 1'b1, 1'b0);
    queue_pixel(16'h0000, 1'b0, 1'b0);
    queue_pixel(16'h0001, 1'b0, 1'b0);
    queue_pixel(16'h8000, 1'b0, 1'b1);
    queue_pixel(16'hFFFF, 1'b1, 1'b1);
    queue_pixel(16'h1234, 1'b0, 1'b0);
    queue_pixel(16'hFFFF, 1'b0, 1'b1);
    queue_pixel(16'h7FFF, 1'b0, 1'b0);
    queue_pixel(16'h0000, 1'b1, 1'b1);
    wait_idle();

    for (int p = 0; p < PHASES; p++) begin
      case (p % 4)
        0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
        1: begin src_idle_pct = 47; snk_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  snk_stall_pct = 47; end
        default: begin src_idle_pct = 28; snk_stall_pct = 28; end
      endcase
      apply_cfg(pick_cfg(p));
      if (p == 4) hold_req = 1'b1;
      queue_region(PHASE_WORDS);
      wait_idle();
    end

    if (mismatches == 0 && expected_out.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
